### rtl/mono_text_framebuffer_engine_defines.svh
// Assertion macros for the framebuffer engine checker.
`ifndef MONO_TEXT_FRAMEBUFFER_ENGINE_DEFINES_SVH
`define MONO_TEXT_FRAMEBUFFER_ENGINE_DEFINES_SVH
// Same-cycle implication, off during reset.
`define MTFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, off during reset.
`define MTFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/mtfb_pkg.sv
// ----------------------------------------------------------------------------
// mtfb_pkg
// Shared types, constants and helpers of the text framebuffer engine.
// ----------------------------------------------------------------------------
`default_nettype none
package mtfb_pkg;
  localparam int FRAME_BYTES   = 1024;
  localparam int PANEL_COLUMNS = 128;
  localparam int GLYPH_COUNT   = 256;
  localparam int GLYPH_BYTES   = 8;
  localparam int FB_AW         = 10;
  localparam int GS_AW         = 11;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] FILL_BYTE    = 8'hff;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_FILL  = 3'd1,
    CMD_PIXEL = 3'd2,
    CMD_CHAR  = 3'd3,
    CMD_CURS  = 3'd4,
    CMD_LOAD  = 3'd5,
    CMD_READ  = 3'd6,
    CMD_NONE  = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_SWEEP, ST_PIX_RD, ST_PIX_WR,
    ST_GLYPH, ST_READ, ST_READ_WAIT, ST_EMIT
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [5:0]  y_pos;
    logic [6:0]  x_pos;
    logic        pixel_on;
    logic [7:0]  char_code;
    logic [10:0] store_address;
    logic [7:0]  store_byte;
  } item_t;

  // front -> back
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  // back -> front
  typedef struct packed {
    logic init_busy;
    logic pop;
  } back_status_t;

  // clamp font width to 1..8
  function automatic logic [3:0] eff_width(input logic [3:0] fw);
    logic [3:0] w;
    w = fw;
    if (fw == 4'd0) w = 4'd1;
    if (fw > 4'd8)  w = 4'd8;
    return w;
  endfunction

  // text columns per line = 128 / width
  function automatic logic [7:0] text_cols(input logic [3:0] w);
    logic [7:0] c;
    case (w)
      4'd1:    c = 8'd128;
      4'd2:    c = 8'd64;
      4'd3:    c = 8'd42;
      4'd4:    c = 8'd32;
      4'd5:    c = 8'd25;
      4'd6:    c = 8'd21;
      4'd7:    c = 8'd18;
      default: c = 8'd16;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

### rtl/mtfb_front.sv
// ----------------------------------------------------------------------------
// mtfb_front
// Input side: decodes commands and buffers items in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module mtfb_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            command,
  input  wire logic [5:0]            y_pos,
  input  wire logic [6:0]            x_pos,
  input  wire logic                  pixel_on,
  input  wire logic [7:0]            char_code,
  input  wire logic [10:0]           store_address,
  input  wire logic [7:0]            store_byte,
  input  wire mtfb_pkg::back_status_t status,
  output mtfb_pkg::queue_out_t       q_out
);
  mtfb_pkg::item_t q_mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push;
  mtfb_pkg::item_t new_item;
  mtfb_pkg::cmd_t  dec_cmd;

  // command decode
  always_comb begin
    case (command)
      3'd0:    dec_cmd = mtfb_pkg::CMD_CLEAR;
      3'd1:    dec_cmd = mtfb_pkg::CMD_FILL;
      3'd2:    dec_cmd = mtfb_pkg::CMD_PIXEL;
      3'd3:    dec_cmd = mtfb_pkg::CMD_CHAR;
      3'd4:    dec_cmd = mtfb_pkg::CMD_CURS;
      3'd5:    dec_cmd = mtfb_pkg::CMD_LOAD;
      3'd6:    dec_cmd = mtfb_pkg::CMD_READ;
      default: dec_cmd = mtfb_pkg::CMD_NONE;
    endcase
  end

  always_comb begin
    new_item.cmd           = dec_cmd;
    new_item.y_pos         = y_pos;
    new_item.x_pos         = x_pos;
    new_item.pixel_on      = pixel_on;
    new_item.char_code     = char_code;
    new_item.store_address = store_address;
    new_item.store_byte    = store_byte;
  end

  // no transfer during the clearing pass or when full
  assign in_stall    = status.init_busy || (count == 2'd2);
  assign push        = in_valid && !in_stall;
  assign q_out.valid = (count != 2'd0);
  assign q_out.item  = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (push) q_mem[wptr] <= new_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (status.pop) rptr <= ~rptr;
      case ({push, status.pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/mtfb_back.sv
// ----------------------------------------------------------------------------
// mtfb_back
// Execution side: frame and glyph memories, cursor, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module mtfb_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [3:0]            cfg_data,
  input  wire mtfb_pkg::queue_out_t  q_in,
  output mtfb_pkg::back_status_t     status,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 read_byte,
  output logic [3:0]                 cursor_line,
  output logic [6:0]                 cursor_column
);
  mtfb_pkg::state_t state, state_next;
  mtfb_pkg::item_t  cur;

  logic [7:0] fb_mem [mtfb_pkg::FRAME_BYTES];
  logic [7:0] gs_mem [mtfb_pkg::GLYPH_COUNT * mtfb_pkg::GLYPH_BYTES];

  logic                      half_height;
  logic [3:0]                font_width;
  logic [3:0]                line;
  logic [6:0]                col;
  logic [mtfb_pkg::FB_AW-1:0] cnt;
  logic [7:0]                sweep_val;
  logic [11:0]               base;
  logic                      pend;
  logic [11:0]               pend_addr;
  logic [7:0]                fb_q, gs_q, rd_byte;

  logic [3:0]  w;
  logic [7:0]  tcols;
  logic [3:0]  pages;
  logic [10:0] col_off;
  logic        take, out_load, last_sweep, glyph_done;
  logic        pix_ok, curs_ok;
  logic [7:0]  col_inc;
  logic [mtfb_pkg::FB_AW-1:0] pix_idx;

  // memory port controls
  logic                       fb_we;
  logic [mtfb_pkg::FB_AW-1:0] fb_waddr, fb_raddr;
  logic [7:0]                 fb_wdata;
  logic [mtfb_pkg::GS_AW-1:0] gs_raddr;

  assign w       = mtfb_pkg::eff_width(font_width);
  assign tcols   = mtfb_pkg::text_cols(w);
  assign pages   = half_height ? 4'd4 : 4'd8;
  assign col_off = {4'b0, col} * {7'b0, w};
  assign col_inc = {1'b0, col} + 8'd1;
  assign take       = (state == mtfb_pkg::ST_IDLE) && q_in.valid;
  assign out_load   = (state == mtfb_pkg::ST_EMIT) && (!out_valid || !out_stall);
  assign last_sweep = (cnt == {mtfb_pkg::FB_AW{1'b1}});
  assign glyph_done = cnt[3];
  assign pix_ok  = !half_height || (q_in.item.y_pos[5] == 1'b0);
  assign curs_ok = ({2'b0, q_in.item.y_pos} < {4'b0, pages}) &&
                   ({1'b0, q_in.item.x_pos} < tcols);
  assign pix_idx = {cur.y_pos[5:3], cur.x_pos};

  assign status.init_busy = (state == mtfb_pkg::ST_INIT);
  assign status.pop       = take;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mtfb_pkg::ST_INIT:  if (last_sweep) state_next = mtfb_pkg::ST_IDLE;
      mtfb_pkg::ST_IDLE: begin
        if (q_in.valid) begin
          case (q_in.item.cmd)
            mtfb_pkg::CMD_CLEAR, mtfb_pkg::CMD_FILL: state_next = mtfb_pkg::ST_SWEEP;
            mtfb_pkg::CMD_PIXEL:
              state_next = pix_ok ? mtfb_pkg::ST_PIX_RD : mtfb_pkg::ST_EMIT;
            mtfb_pkg::CMD_CHAR:
              state_next = (q_in.item.char_code == mtfb_pkg::NEWLINE_CODE) ?
                           mtfb_pkg::ST_EMIT : mtfb_pkg::ST_GLYPH;
            mtfb_pkg::CMD_READ: state_next = mtfb_pkg::ST_READ;
            default:            state_next = mtfb_pkg::ST_EMIT;
          endcase
        end
      end
      mtfb_pkg::ST_SWEEP:     if (last_sweep) state_next = mtfb_pkg::ST_EMIT;
      mtfb_pkg::ST_PIX_RD:    state_next = mtfb_pkg::ST_PIX_WR;
      mtfb_pkg::ST_PIX_WR:    state_next = mtfb_pkg::ST_EMIT;
      mtfb_pkg::ST_GLYPH:     if (glyph_done) state_next = mtfb_pkg::ST_EMIT;
      mtfb_pkg::ST_READ:      state_next = mtfb_pkg::ST_READ_WAIT;
      mtfb_pkg::ST_READ_WAIT: state_next = mtfb_pkg::ST_EMIT;
      mtfb_pkg::ST_EMIT:      if (out_load) state_next = mtfb_pkg::ST_IDLE;
      default:                state_next = mtfb_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    fb_we    = 1'b0;
    fb_waddr = cnt;
    fb_wdata = sweep_val;
    fb_raddr = pix_idx;
    gs_raddr = {cur.char_code, cnt[2:0]};
    case (state)
      mtfb_pkg::ST_INIT: begin
        fb_we    = 1'b1;
        fb_wdata = 8'h00;
      end
      mtfb_pkg::ST_SWEEP: fb_we = 1'b1;
      mtfb_pkg::ST_PIX_WR: begin
        fb_we    = 1'b1;
        fb_waddr = pix_idx;
        fb_wdata = cur.pixel_on ? (fb_q | (8'h01 << cur.y_pos[2:0]))
                                : (fb_q & ~(8'h01 << cur.y_pos[2:0]));
      end
      mtfb_pkg::ST_GLYPH: begin
        fb_we    = pend && (pend_addr[11:10] == 2'b00);
        fb_waddr = pend_addr[mtfb_pkg::FB_AW-1:0];
        fb_wdata = gs_q;
      end
      mtfb_pkg::ST_READ: fb_raddr = cur.store_address[mtfb_pkg::FB_AW-1:0];
      default: ;
    endcase
  end

  // frame memory
  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
    fb_q <= fb_mem[fb_raddr];
  end

  // glyph memory
  always_ff @(posedge clk) begin
    if (take && q_in.item.cmd == mtfb_pkg::CMD_LOAD)
      gs_mem[q_in.item.store_address] <= q_in.item.store_byte;
    gs_q <= gs_mem[gs_raddr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (take) begin
      cur       <= q_in.item;
      sweep_val <= (q_in.item.cmd == mtfb_pkg::CMD_FILL) ? mtfb_pkg::FILL_BYTE : 8'h00;
      base      <= {1'b0, line, 7'b0} + {1'b0, col_off};
      rd_byte   <= 8'h00;
    end
    pend      <= (state == mtfb_pkg::ST_GLYPH) && !glyph_done;
    pend_addr <= base + {8'b0, cnt[3:0]};
    if (state == mtfb_pkg::ST_READ_WAIT)
      rd_byte <= (cur.store_address[10] == 1'b0) ? fb_q : 8'h00;
    if (out_load) begin
      read_byte     <= rd_byte;
      cursor_line   <= line;
      cursor_column <= col;
    end
  end

  // control registers: state, counter, cursor, config, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mtfb_pkg::ST_INIT;
      cnt         <= '0;
      line        <= 4'd0;
      col         <= 7'd0;
      half_height <= 1'b0;
      font_width  <= 4'd8;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (take) cnt <= '0;
      else if (state == mtfb_pkg::ST_INIT || state == mtfb_pkg::ST_SWEEP ||
               state == mtfb_pkg::ST_GLYPH) cnt <= cnt + mtfb_pkg::FB_AW'(1);
      if (cfg_we) begin
        if (cfg_index) font_width  <= cfg_data;
        else           half_height <= cfg_data[0];
      end
      // cursor updates
      if (take && q_in.item.cmd == mtfb_pkg::CMD_CURS && curs_ok) begin
        line <= q_in.item.y_pos[3:0];
        col  <= q_in.item.x_pos;
      end else if (take && q_in.item.cmd == mtfb_pkg::CMD_CHAR &&
                   q_in.item.char_code == mtfb_pkg::NEWLINE_CODE) begin
        col <= 7'd0;
        if (line < pages) line <= line + 4'd1;
      end else if (state == mtfb_pkg::ST_GLYPH && glyph_done) begin
        if (col_inc >= tcols) begin
          col <= 7'd0;
          if (line < pages) line <= line + 4'd1;
        end else begin
          col <= col_inc[6:0];
        end
      end
      if (out_load)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### rtl/mono_text_framebuffer_engine.sv
// ----------------------------------------------------------------------------
// mono_text_framebuffer_engine
// 128x64 page-organised 1-bit framebuffer with glyph store and text cursor.
// ----------------------------------------------------------------------------
// Every accepted command returns one result (read byte and cursor). After
// reset the frame memory is swept to zero, during which in_stall is high.
// The execution side handles one command at a time. On a character it
// decodes, copies the eight glyph bytes from the glyph store into the frame
// memory one a cycle and returns the result; on a pixel it reads, modifies
// and writes; on a read it reads the frame memory; clear and fill write
// one frame byte per cycle; other commands only decode and return the
// result. The result is registered as the execution side leaves its emit
// state. A two-entry queue accepts items while the execution side works.
`default_nettype none
module mono_text_framebuffer_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [5:0]  y_pos,
  input  wire logic [6:0]  x_pos,
  input  wire logic        pixel_on,
  input  wire logic [7:0]  char_code,
  input  wire logic [10:0] store_address,
  input  wire logic [7:0]  store_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_byte,
  output logic [3:0]       cursor_line,
  output logic [6:0]       cursor_column
);
  mtfb_pkg::queue_out_t   q_out;
  mtfb_pkg::back_status_t status;

  mtfb_front u_front (
    .clk, .rst, .in_valid, .in_stall, .command, .y_pos, .x_pos, .pixel_on,
    .char_code, .store_address, .store_byte, .status, .q_out
  );

  mtfb_back u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .q_in(q_out), .status,
    .out_valid, .out_stall, .read_byte, .cursor_line, .cursor_column
  );
endmodule
`default_nettype wire

### rtl/mtfb_checker.sv
// ----------------------------------------------------------------------------
// mtfb_checker
// Port-level checks of the framebuffer engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mono_text_framebuffer_engine_defines.svh"
module mtfb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic        cfg_index,
  input wire logic [3:0]  cfg_data,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [2:0]  command,
  input wire logic [5:0]  y_pos,
  input wire logic [6:0]  x_pos,
  input wire logic        pixel_on,
  input wire logic [7:0]  char_code,
  input wire logic [10:0] store_address,
  input wire logic [7:0]  store_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  read_byte,
  input wire logic [3:0]  cursor_line,
  input wire logic [6:0]  cursor_column
);
  // stalled result stays
  `MTFB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
  `MTFB_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(read_byte) && $stable(cursor_line) && $stable(cursor_column), "stalled result changed")
  // cursor line never passes eight, the full-height page count
  `MTFB_ASSERT_NOW(a_line_range, out_valid, cursor_line <= 4'd8, "cursor line out of range")
  // clearing pass blocks input right after reset
  `MTFB_ASSERT_NOW(a_init_stall, $past(rst), in_stall, "input taken during clearing pass")
endmodule
bind mono_text_framebuffer_engine mtfb_checker u_chk (.*);
`default_nettype wire

### tb/mono_text_framebuffer_engine_tb.sv
// ----------------------------------------------------------------------------
// mono_text_framebuffer_engine_tb
// Self-checking bench for the text framebuffer engine: a local predictor of
// frame, glyph store and cursor checks every result in order, across
// register settings and random idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mono_text_framebuffer_engine_tb;

  localparam logic CFG_HALF  = 1'b0;
  localparam logic CFG_WIDTH = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_HALF;
  logic [3:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = mtfb_pkg::CMD_NONE;
  logic [5:0]  y_pos = '0;
  logic [6:0]  x_pos = '0;
  logic        pixel_on = 1'b0;
  logic [7:0]  char_code = '0;
  logic [10:0] store_address = '0;
  logic [7:0]  store_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_byte;
  logic [3:0]  cursor_line;
  logic [6:0]  cursor_column;

  mono_text_framebuffer_engine uut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [7:0]  frame_mem [mtfb_pkg::FRAME_BYTES];
  logic [7:0]  glyph_mem [mtfb_pkg::GLYPH_COUNT*mtfb_pkg::GLYPH_BYTES];
  logic [3:0]  pred_line;
  logic [6:0]  pred_col;
  logic        pred_half;
  logic [3:0]  pred_width;

  typedef struct packed {
    logic [7:0] rd;
    logic [3:0] line;
    logic [6:0] col;
  } result_t;
  result_t expected_results [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int cell_w();
    if (pred_width == 0) return 1;
    if (pred_width > 8) return 8;
    return pred_width;
  endfunction

  function automatic int line_count();
    return pred_half ? 4 : 8;
  endfunction

  function automatic void line_feed();
    pred_col = 0;
    if (pred_line < line_count()) pred_line++;
  endfunction

  // only glyphs 0x00-0x0f and 0xf0-0xff are loaded; pick a code among them
  function automatic logic [7:0] loaded_code();
    return {($urandom_range(1) != 0) ? 4'hf : 4'h0, 4'($urandom_range(15))};
  endfunction

  // compute the result of one command and update the predicted state
  function automatic result_t predict_frame_result(input logic [2:0] c, input logic [5:0] y,
      input logic [6:0] x, input logic on, input logic [7:0] ch, input logic [10:0] a,
      input logic [7:0] b);
    result_t r;
    int base, g;
    r.rd = '0;
    case (c)
      mtfb_pkg::CMD_CLEAR: foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      mtfb_pkg::CMD_FILL:  foreach (frame_mem[i]) frame_mem[i] = mtfb_pkg::FILL_BYTE;
      mtfb_pkg::CMD_PIXEL: begin
        if (y < line_count()*8)
          frame_mem[(y>>3)*mtfb_pkg::PANEL_COLUMNS + x][y[2:0]] = on;
      end
      mtfb_pkg::CMD_CHAR: begin
        if (ch == mtfb_pkg::NEWLINE_CODE) line_feed();
        else begin
          base = pred_line*mtfb_pkg::PANEL_COLUMNS + pred_col*cell_w();
          g = ch*mtfb_pkg::GLYPH_BYTES;
          for (int k = 0; k < mtfb_pkg::GLYPH_BYTES; k++)
            if (base + k < mtfb_pkg::FRAME_BYTES) frame_mem[base+k] = glyph_mem[g+k];
          // column count can be 128, so compare before the 7-bit register wraps
          if (int'(pred_col) + 1 >= mtfb_pkg::PANEL_COLUMNS/cell_w()) line_feed();
          else pred_col++;
        end
      end
      mtfb_pkg::CMD_CURS: begin
        if (y < line_count() && x < mtfb_pkg::PANEL_COLUMNS/cell_w()) begin
          pred_line = y[3:0];
          pred_col = x;
        end
      end
      mtfb_pkg::CMD_LOAD: glyph_mem[a] = b;
      mtfb_pkg::CMD_READ: if (a < mtfb_pkg::FRAME_BYTES) r.rd = frame_mem[a];
      default: ;
    endcase
    r.line = pred_line;
    r.col = pred_col;
    return r;
  endfunction

  // one input transfer; valid stays high until the next idle cycle or drain
  task automatic send_command(input logic [2:0] c, input logic [5:0] y, input logic [6:0] x,
      input logic on, input logic [7:0] ch, input logic [10:0] a, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    expected_results.push_back(predict_frame_result(c, y, x, on, ch, a, b));
    in_valid <= 1'b1;
    command <= c; y_pos <= y; x_pos <= x; pixel_on <= on;
    char_code <= ch; store_address <= a; store_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_command(input int weight_char);
    logic [2:0] c;
    logic [7:0] ch;
    int p;
    p = $urandom_range(99);
    if (p < weight_char) c = mtfb_pkg::CMD_CHAR;
    else if (p < weight_char + 25) c = mtfb_pkg::CMD_PIXEL;
    else if (p < weight_char + 40) c = mtfb_pkg::CMD_READ;
    else if (p < weight_char + 50) c = mtfb_pkg::CMD_CURS;
    else if (p < weight_char + 55) c = mtfb_pkg::CMD_LOAD;
    else c = (p % 3 == 0) ? mtfb_pkg::CMD_NONE :
             ((p % 31 == 0) ? mtfb_pkg::CMD_FILL : mtfb_pkg::CMD_PIXEL);
    ch = loaded_code();
    if ($urandom_range(9) == 0) ch = mtfb_pkg::NEWLINE_CODE;
    send_command(c, 6'($urandom_range(63)),
                 (c == mtfb_pkg::CMD_CURS && $urandom_range(1) != 0) ?
                   7'($urandom_range(20)) : 7'($urandom_range(127)),
                 1'($urandom_range(1)), ch, 11'($urandom_range(2047)),
                 8'($urandom_range(255)));
  endtask

  // wait until every expectation is met, then let the block go idle
  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_HALF) pred_half = val[0];
    else pred_width = val;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          w = expected_results.pop_front();
          if (read_byte !== w.rd) report_mismatch("read_byte", read_byte, w.rd);
          if (cursor_line !== w.line) report_mismatch("cursor_line", cursor_line, w.line);
          if (cursor_column !== w.col) report_mismatch("cursor_column", cursor_column, w.col);
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  // long receiver hold-off, counted here
  task automatic test_backpressure();
    int cnt;
    hold_off = 1'b1;
    fork
      begin
        cnt = 0;
        while (cnt < 300) begin
          @(posedge clk);
          cnt++;
        end
        hold_off = 1'b0;
      end
      repeat (12) send_random_command(40);
    join
    drain();
  endtask

  // load the low and high sixteen glyphs; only those codes are ever drawn
  task automatic test_font_load();
    int code;
    for (int g = 0; g < 32; g++) begin
      code = (g < 16) ? g : g + 224;
      for (int k = 0; k < mtfb_pkg::GLYPH_BYTES; k++)
        send_command(mtfb_pkg::CMD_LOAD, 0, 0, 0, 0,
                     11'(code*mtfb_pkg::GLYPH_BYTES + k), 8'($urandom_range(255)));
    end
    send_command(mtfb_pkg::CMD_LOAD, 0, 0, 0, 0, 11'h7ff, 8'hff);
    drain();
  endtask

  task automatic test_directed();
    send_command(mtfb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
    send_command(mtfb_pkg::CMD_FILL, 0, 0, 0, 0, 0, 0);
    send_command(mtfb_pkg::CMD_READ, 0, 0, 0, 0, 1023, 0);
    send_command(mtfb_pkg::CMD_READ, 0, 0, 0, 0, 1024, 0);
    send_command(mtfb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_command(mtfb_pkg::CMD_PIXEL, 63, 127, 1, 0, 0, 0);
    send_command(mtfb_pkg::CMD_READ, 0, 0, 0, 0, 1023, 0);
    send_command(mtfb_pkg::CMD_PIXEL, 63, 127, 0, 0, 0, 0);
    send_command(mtfb_pkg::CMD_PIXEL, 0, 0, 1, 0, 0, 0);
    send_command(mtfb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
    send_command(mtfb_pkg::CMD_CURS, 7, 15, 0, 0, 0, 0);
    send_command(mtfb_pkg::CMD_CHAR, 0, 0, 0, 8'hff, 0, 0);
    send_command(mtfb_pkg::CMD_CHAR, 0, 0, 0, 8'h05, 0, 0);
    send_command(mtfb_pkg::CMD_CHAR, 0, 0, 0, mtfb_pkg::NEWLINE_CODE, 0, 0);
    send_command(mtfb_pkg::CMD_CURS, 8, 0, 0, 0, 0, 0);
    send_command(mtfb_pkg::CMD_CURS, 0, 16, 0, 0, 0, 0);
    send_command(mtfb_pkg::CMD_CURS, 7, 0, 0, 0, 0, 0);
    send_command(mtfb_pkg::CMD_CHAR, 0, 0, 0, 8'h00, 0, 0);
    send_command(mtfb_pkg::CMD_READ, 0, 0, 0, 0, 896, 0);
    send_command(mtfb_pkg::CMD_NONE, 63, 127, 1, 255, 2047, 255);
    drain();
  endtask

  // both height settings and six font widths, with extremes, random content
  task automatic test_random_settings();
    int halves [6] = '{0, 1, 0, 1, 0, 1};
    int widths [6] = '{1, 8, 0, 15, 3, 5};
    int idle [4] = '{0, 45, 0, 28};
    int stl [4] = '{0, 0, 45, 28};
    for (int s = 0; s < 6; s++) begin
      write_reg(CFG_HALF, 4'(halves[s]));
      write_reg(CFG_WIDTH, 4'(widths[s]));
      if (halves[s] != 0) begin
        send_command(mtfb_pkg::CMD_PIXEL, 32, 5, 1, 0, 0, 0);
        send_command(mtfb_pkg::CMD_CURS, 4, 0, 0, 0, 0, 0);
      end
      for (int i = 0; i < 100; i++) begin
        send_idle_pct = idle[(i/25)%4];
        stall_pct = stl[(i/25)%4];
        send_random_command(45);
      end
      send_idle_pct = 0; stall_pct = 0;
      drain();
    end
  endtask

  initial begin
    pred_line = 0; pred_col = 0; pred_half = 0; pred_width = 8;
    foreach (frame_mem[i]) frame_mem[i] = 8'h00;
    foreach (glyph_mem[i]) glyph_mem[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_font_load();
    test_directed();
    test_backpressure();
    test_random_settings();
    $display("Covered %0d commands, %0d results, all register extremes and handshake phases.",
             items_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_results.size() != 0) $display("%0d results never arrived",
                                                 expected_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("Timeout");
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
